>>> hdl/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types, constants, fixed-point helpers and the step table of the
// natural cubic spline coefficient engine.
// ----------------------------------------------------------------------------
package ncs_pkg;

    localparam int NCS_MAX_POINTS = 64;
    localparam int NCS_S_DATA_W   = 64;
    localparam int NCS_M_DATA_W   = 264;
    localparam int NCS_M_USER_W   = 2;
    localparam int NCS_SEG_W      = 6;
    localparam int NCS_PC_W       = 6;

    localparam logic signed [63:0] FX_ZERO  = 64'sh0;
    localparam logic signed [63:0] FX_SIX   = 64'sh6_0000_0000;
    localparam logic signed [63:0] FX_THREE = 64'sh3_0000_0000;
    localparam logic signed [63:0] FX_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] FX_MIN   = 64'sh8000_0000_0000_0000;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FEW   = 2'd1;
    localparam logic [1:0] ERR_ORDER = 2'd2;

    // step table landmarks
    localparam logic [NCS_PC_W-1:0] PC_SLOPE_FIRST = 6'd0;
    localparam logic [NCS_PC_W-1:0] PC_SLOPE_END   = 6'd2;
    localparam logic [NCS_PC_W-1:0] PC_SOLVE_FIRST = 6'd3;
    localparam logic [NCS_PC_W-1:0] PC_SOLVE_END   = 6'd11;
    localparam logic [NCS_PC_W-1:0] PC_SEG_FIRST   = 6'd12;
    localparam logic [NCS_PC_W-1:0] PC_SEG_END     = 6'd40;
    localparam logic [NCS_PC_W-1:0] PC_BS_FIRST    = 6'd41;
    localparam logic [NCS_PC_W-1:0] PC_BS_END      = 6'd42;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_SIX, SRC_THREE, SRC_X0, SRC_X1, SRC_Y0, SRC_Y1, SRC_G0, SRC_G1,
        SRC_H, SRC_D, SRC_S, SRC_H6, SRC_U0, SRC_U1, SRC_HH, SRC_SQ0, SRC_SQ1,
        SRC_P, SRC_Q, SRC_T, SRC_T0, SRC_E, SRC_SP, SRC_AP, SRC_BP, SRC_RHS,
        SRC_DEN, SRC_SUBD, SRC_SUPD, SRC_HSUM2
    } src_t;

    typedef enum logic [4:0] {
        DST_H, DST_D, DST_S, DST_H6, DST_U0, DST_U1, DST_HH, DST_SQ0, DST_SQ1,
        DST_P, DST_Q, DST_T, DST_T0, DST_E, DST_RHS, DST_DEN,
        DST_C3, DST_C2, DST_C1, DST_C0, DST_G1
    } dst_t;

    typedef struct packed {
        op_t  op;
        dst_t dst;
        src_t sa;
        src_t sb;
    } uop_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } arith_req_t;

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? FX_MIN : FX_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? FX_MIN : FX_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag(logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] from_mag(logic neg, logic [63:0] m);
        if (neg) begin
            return m[63] ? FX_MIN : -$signed(m);
        end
        return m[63] ? FX_MAX : $signed(m);
    endfunction

    function automatic logic signed [63:0] widen(logic [31:0] v);
        return $signed({{16{v[31]}}, v, 16'h0000});
    endfunction

    function automatic uop_t ncs_uop(logic [NCS_PC_W-1:0] pc);
        uop_t u;
        u = '{OP_ADD, DST_T, SRC_ZERO, SRC_ZERO};
        unique case (pc)
            6'd0:  u = '{OP_SUB, DST_H,   SRC_X1,    SRC_X0};
            6'd1:  u = '{OP_SUB, DST_D,   SRC_Y1,    SRC_Y0};
            6'd2:  u = '{OP_DIV, DST_S,   SRC_D,     SRC_H};
            6'd3:  u = '{OP_SUB, DST_T,   SRC_S,     SRC_SP};
            6'd4:  u = '{OP_MUL, DST_RHS, SRC_T,     SRC_SIX};
            6'd5:  u = '{OP_MUL, DST_P,   SRC_SUBD,  SRC_AP};
            6'd6:  u = '{OP_ADD, DST_DEN, SRC_HSUM2, SRC_P};
            6'd7:  u = '{OP_SUB, DST_T,   SRC_ZERO,  SRC_SUPD};
            6'd8:  u = '{OP_DIV, DST_P,   SRC_T,     SRC_DEN};
            6'd9:  u = '{OP_MUL, DST_Q,   SRC_SUBD,  SRC_BP};
            6'd10: u = '{OP_SUB, DST_T,   SRC_RHS,   SRC_Q};
            6'd11: u = '{OP_DIV, DST_Q,   SRC_T,     SRC_DEN};
            6'd12: u = '{OP_MUL, DST_H6,  SRC_H,     SRC_SIX};
            6'd13: u = '{OP_DIV, DST_U0,  SRC_G0,    SRC_H6};
            6'd14: u = '{OP_DIV, DST_U1,  SRC_G1,    SRC_H6};
            6'd15: u = '{OP_MUL, DST_HH,  SRC_H,     SRC_H};
            6'd16: u = '{OP_MUL, DST_SQ0, SRC_X0,    SRC_X0};
            6'd17: u = '{OP_MUL, DST_SQ1, SRC_X1,    SRC_X1};
            6'd18: u = '{OP_SUB, DST_C3,  SRC_U1,    SRC_U0};
            6'd19: u = '{OP_MUL, DST_P,   SRC_U0,    SRC_X1};
            6'd20: u = '{OP_MUL, DST_Q,   SRC_U1,    SRC_X0};
            6'd21: u = '{OP_SUB, DST_T,   SRC_P,     SRC_Q};
            6'd22: u = '{OP_MUL, DST_C2,  SRC_THREE, SRC_T};
            6'd23: u = '{OP_MUL, DST_T,   SRC_THREE, SRC_SQ1};
            6'd24: u = '{OP_SUB, DST_T,   SRC_HH,    SRC_T};
            6'd25: u = '{OP_MUL, DST_P,   SRC_U0,    SRC_T};
            6'd26: u = '{OP_MUL, DST_T,   SRC_THREE, SRC_SQ0};
            6'd27: u = '{OP_SUB, DST_T,   SRC_HH,    SRC_T};
            6'd28: u = '{OP_MUL, DST_Q,   SRC_U1,    SRC_T};
            6'd29: u = '{OP_SUB, DST_T,   SRC_P,     SRC_Q};
            6'd30: u = '{OP_ADD, DST_C1,  SRC_S,     SRC_T};
            6'd31: u = '{OP_MUL, DST_P,   SRC_X0,    SRC_S};
            6'd32: u = '{OP_SUB, DST_T0,  SRC_Y0,    SRC_P};
            6'd33: u = '{OP_SUB, DST_D,   SRC_SQ1,   SRC_HH};
            6'd34: u = '{OP_MUL, DST_E,   SRC_X1,    SRC_D};
            6'd35: u = '{OP_MUL, DST_P,   SRC_U0,    SRC_E};
            6'd36: u = '{OP_SUB, DST_D,   SRC_HH,    SRC_SQ0};
            6'd37: u = '{OP_MUL, DST_E,   SRC_X0,    SRC_D};
            6'd38: u = '{OP_MUL, DST_Q,   SRC_U1,    SRC_E};
            6'd39: u = '{OP_ADD, DST_T,   SRC_P,     SRC_Q};
            6'd40: u = '{OP_ADD, DST_C0,  SRC_T0,    SRC_T};
            6'd41: u = '{OP_MUL, DST_P,   SRC_AP,    SRC_G1};
            6'd42: u = '{OP_ADD, DST_G1,  SRC_P,     SRC_BP};
            default: u = '{OP_ADD, DST_T, SRC_ZERO, SRC_ZERO};
        endcase
        return u;
    endfunction

endpackage

>>> hdl/ncs_arith.sv
// ----------------------------------------------------------------------------
// ncs_arith
// Shared Q32.32 unit: saturating add and subtract, a multiply built from four
// 32x32 partial products, and a restoring divide that yields one quotient bit
// per cycle. Results are rounded to nearest, ties away from zero, and
// saturated.
// ----------------------------------------------------------------------------
module ncs_arith
    import ncs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  arith_req_t         req,
    input  logic signed [63:0] opa,
    input  logic signed [63:0] opb,
    output logic               done,
    output logic signed [63:0] result
);

    typedef enum logic [3:0] {
        AR_IDLE = 4'b0001,
        AR_MUL  = 4'b0010,
        AR_DIV  = 4'b0100,
        AR_FIN  = 4'b1000
    } ar_state_t;

    ar_state_t          state_reg;
    logic               is_div_reg;
    logic               neg_reg;
    logic [63:0]        ua_reg;
    logic [63:0]        ub_reg;
    logic [127:0]       acc_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic [63:0]        sh_reg;
    logic [5:0]         cnt_reg;
    logic               done_reg;
    logic signed [63:0] result_reg;

    logic [63:0]  ua_in, ub_in;
    logic         neg_in;
    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod;
    logic [127:0] prod_ext;
    logic [64:0]  rem_shift;
    logic [127:0] mul_round;
    logic [63:0]  rem_gap;

    assign ua_in  = mag(opa);
    assign ub_in  = mag(opb);
    assign neg_in = opa[63] ^ opb[63];

    assign mul_a = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
    assign mul_b = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
    assign prod  = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0:    prod_ext = {64'h0, prod};
            2'd3:    prod_ext = {prod, 64'h0};
            default: prod_ext = {32'h0, prod, 32'h0};
        endcase
    end

    assign rem_shift = {rem_reg, sh_reg[63]};
    assign mul_round = acc_reg + 128'h8000_0000;
    assign rem_gap   = ub_reg - rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AR_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                AR_IDLE: begin
                    if (req.start) begin
                        neg_reg <= neg_in;
                        ua_reg  <= ua_in;
                        ub_reg  <= ub_in;
                        cnt_reg <= '0;
                        unique case (req.op)
                            OP_ADD: begin
                                result_reg <= sat_add(opa, opb);
                                done_reg   <= 1'b1;
                            end
                            OP_SUB: begin
                                result_reg <= sat_sub(opa, opb);
                                done_reg   <= 1'b1;
                            end
                            OP_MUL: begin
                                acc_reg    <= '0;
                                is_div_reg <= 1'b0;
                                state_reg  <= AR_MUL;
                            end
                            OP_DIV: begin
                                is_div_reg <= 1'b1;
                                if (opb == FX_ZERO) begin
                                    result_reg <= (opa == FX_ZERO) ? FX_ZERO :
                                                  (opa[63] ? FX_MIN : FX_MAX);
                                    done_reg   <= 1'b1;
                                end else if (64'(ua_in[63:32]) >= ub_in) begin
                                    result_reg <= from_mag(neg_in, '1);
                                    done_reg   <= 1'b1;
                                end else begin
                                    rem_reg   <= 64'(ua_in[63:32]);
                                    sh_reg    <= {ua_in[31:0], 32'h0};
                                    quo_reg   <= '0;
                                    state_reg <= AR_DIV;
                                end
                            end
                            default: state_reg <= AR_IDLE;
                        endcase
                    end
                end
                AR_MUL: begin
                    acc_reg <= acc_reg + prod_ext;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[1:0] == 2'd3) begin
                        state_reg <= AR_FIN;
                    end
                end
                AR_DIV: begin
                    sh_reg  <= {sh_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (rem_shift >= {1'b0, ub_reg}) begin
                        rem_reg <= 64'(rem_shift - {1'b0, ub_reg});
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 6'd63) begin
                        state_reg <= AR_FIN;
                    end
                end
                AR_FIN: begin
                    done_reg  <= 1'b1;
                    state_reg <= AR_IDLE;
                    if (is_div_reg) begin
                        // round half up on the remainder
                        if (rem_reg >= rem_gap && quo_reg == '1) begin
                            result_reg <= from_mag(neg_reg, '1);
                        end else if (rem_reg >= rem_gap) begin
                            result_reg <= from_mag(neg_reg, quo_reg + 64'd1);
                        end else begin
                            result_reg <= from_mag(neg_reg, quo_reg);
                        end
                    end else if (mul_round[127:96] != 32'h0) begin
                        result_reg <= from_mag(neg_reg, '1);
                    end else begin
                        result_reg <= from_mag(neg_reg, mul_round[95:32]);
                    end
                end
                default: state_reg <= AR_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hdl/natural_cubic_spline_coefficients.sv
// ----------------------------------------------------------------------------
// natural_cubic_spline_coefficients
// Collects knots, solves the natural-spline system by a Thomas sweep and back
// substitution, and streams the power-basis coefficients of each segment.
//
//   channel | dir | tdata                          | tuser       | tlast
//   s_      | in  | x_pos, y_val                   | -           | last_point
//   m_      | out | segment_index, c3, c2, c1, c0  | error_code  | last_segment
//
// Knots are taken while the engine is idle. After the closing knot the shared
// arithmetic unit sets the pace of the sweep, the back substitution and the
// segment steps.
// The input stays stalled from the closing knot until the last result leaves.
// A stalled result holds its word. Reset clears the knot count and sequencer;
// the knot and sweep memories need no clearing.
// ----------------------------------------------------------------------------
module natural_cubic_spline_coefficients
    import ncs_pkg::*;
#(
    parameter int MAX_POINTS = NCS_MAX_POINTS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [NCS_S_DATA_W-1:0] s_tdata,   // x_pos, y_val
    input  logic                    s_tlast,   // last_point
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [NCS_M_DATA_W-1:0] m_tdata,   // segment_index, c3, c2, c1, c0, pad
    output logic [NCS_M_USER_W-1:0] m_tuser,   // error_code
    output logic                    m_tlast    // last_segment
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [19:0] {
        ST_IDLE    = 20'h00001,
        ST_P_RD0   = 20'h00002,
        ST_P_RD1   = 20'h00004,
        ST_P_CAP   = 20'h00008,
        ST_RUN     = 20'h00010,
        ST_P_SHIFT = 20'h00020,
        ST_S_RD    = 20'h00040,
        ST_S_CAP   = 20'h00080,
        ST_S_ST    = 20'h00100,
        ST_B_END   = 20'h00200,
        ST_B_N2    = 20'h00400,
        ST_B_RD    = 20'h00800,
        ST_B_CAP   = 20'h01000,
        ST_B_ST    = 20'h02000,
        ST_B_Z     = 20'h04000,
        ST_G_RD0   = 20'h08000,
        ST_G_RD1   = 20'h10000,
        ST_G_CAP   = 20'h20000,
        ST_G_DONE  = 20'h40000,
        ST_OUT     = 20'h80000
    } state_t;

    typedef enum logic [1:0] {MD_PRO, MD_SOLVE, MD_SEG, MD_BS} mode_t;

    // knot and sweep memories
    logic [31:0] x_mem [MAX_POINTS];
    logic [31:0] y_mem [MAX_POINTS];
    logic [63:0] a_mem [MAX_POINTS];
    logic [63:0] b_mem [MAX_POINTS];
    logic [63:0] g_mem [MAX_POINTS];
    logic [31:0] x_rd_reg, y_rd_reg;
    logic [63:0] a_rd_reg, b_rd_reg, g_rd_reg;

    state_t            state_reg, state_next;
    mode_t             mode_reg;
    logic [CW-1:0]     cnt_reg;
    logic              ord_err_reg;
    logic signed [31:0] last_x_reg;
    logic [CW-1:0]     n_reg;
    logic [IW-1:0]     idx_reg;
    logic [NCS_PC_W-1:0] pc_reg;
    logic              issued_reg;

    logic signed [63:0] x0_reg, x1_reg, y0_reg, y1_reg, g0_reg, g1_reg;
    logic signed [63:0] h_reg, d_reg, s_reg, h6_reg, u0_reg, u1_reg;
    logic signed [63:0] hh_reg, sq0_reg, sq1_reg, p_reg, q_reg, t_reg, t0_reg, e_reg;
    logic signed [63:0] hp_reg, sp_reg, ap_reg, bp_reg, rhs_reg, den_reg;
    logic signed [63:0] c3_reg, c2_reg, c1_reg, c0_reg;

    logic [NCS_SEG_W-1:0] out_idx_reg;
    logic signed [63:0]   out_c3_reg, out_c2_reg, out_c1_reg, out_c0_reg;
    logic [1:0]           out_err_reg;
    logic                 out_last_reg;

    logic               s_fire;
    logic               room;
    logic [CW-1:0]      n_eff;
    logic               ord_hit;
    logic [IW-1:0]      rd_addr;
    logic               g_we;
    logic [IW-1:0]      g_waddr;
    logic [63:0]        g_wdata;
    logic               first_row;
    logic               end_row;
    uop_t               uop;
    arith_req_t         req;
    logic signed [63:0] opa, opb;
    logic               ar_done;
    logic signed [63:0] ar_result;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign room      = (cnt_reg < CW'(MAX_POINTS));
    assign n_eff     = room ? cnt_reg + CW'(1) : cnt_reg;
    assign ord_hit   = room && (cnt_reg != '0) &&
                       ($signed(s_tdata[31:0]) <= last_x_reg);
    assign first_row = (idx_reg == IW'(1));
    assign end_row   = ((CW'(idx_reg) + CW'(2)) == n_reg);

    always_comb begin
        unique case (state_reg)
            ST_P_RD0: rd_addr = '0;
            ST_P_RD1: rd_addr = IW'(1);
            ST_S_RD:  rd_addr = idx_reg + IW'(1);
            ST_G_RD1: rd_addr = idx_reg + IW'(1);
            default:  rd_addr = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire && room) begin
            x_mem[cnt_reg[IW-1:0]] <= s_tdata[31:0];
            y_mem[cnt_reg[IW-1:0]] <= s_tdata[63:32];
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_S_ST) begin
            a_mem[idx_reg] <= p_reg;
            b_mem[idx_reg] <= q_reg;
        end
        a_rd_reg <= a_mem[rd_addr];
        b_rd_reg <= b_mem[rd_addr];
    end

    always_comb begin
        g_we    = 1'b0;
        g_waddr = idx_reg;
        g_wdata = g1_reg;
        unique case (state_reg)
            ST_B_END: begin
                g_we    = 1'b1;
                g_waddr = IW'(n_reg - CW'(1));
                g_wdata = '0;
            end
            ST_B_N2: begin
                g_we    = 1'b1;
                g_waddr = IW'(n_reg - CW'(2));
                g_wdata = bp_reg;
            end
            ST_B_ST: g_we = 1'b1;
            ST_B_Z: begin
                g_we    = 1'b1;
                g_waddr = '0;
                g_wdata = '0;
            end
            default: g_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (g_we) begin
            g_mem[g_waddr] <= g_wdata;
        end
        g_rd_reg <= g_mem[rd_addr];
    end

    // operand selection for the shared unit
    assign uop = ncs_uop(pc_reg);

    function automatic logic signed [63:0] pick(src_t sel);
        logic signed [63:0] v;
        unique case (sel)
            SRC_ZERO:  v = FX_ZERO;
            SRC_SIX:   v = FX_SIX;
            SRC_THREE: v = FX_THREE;
            SRC_X0:    v = x0_reg;
            SRC_X1:    v = x1_reg;
            SRC_Y0:    v = y0_reg;
            SRC_Y1:    v = y1_reg;
            SRC_G0:    v = g0_reg;
            SRC_G1:    v = g1_reg;
            SRC_H:     v = h_reg;
            SRC_D:     v = d_reg;
            SRC_S:     v = s_reg;
            SRC_H6:    v = h6_reg;
            SRC_U0:    v = u0_reg;
            SRC_U1:    v = u1_reg;
            SRC_HH:    v = hh_reg;
            SRC_SQ0:   v = sq0_reg;
            SRC_SQ1:   v = sq1_reg;
            SRC_P:     v = p_reg;
            SRC_Q:     v = q_reg;
            SRC_T:     v = t_reg;
            SRC_T0:    v = t0_reg;
            SRC_E:     v = e_reg;
            SRC_SP:    v = sp_reg;
            SRC_AP:    v = ap_reg;
            SRC_BP:    v = bp_reg;
            SRC_RHS:   v = rhs_reg;
            SRC_DEN:   v = den_reg;
            SRC_SUBD:  v = first_row ? FX_ZERO : hp_reg;
            SRC_SUPD:  v = end_row ? FX_ZERO : h_reg;
            SRC_HSUM2: v = (hp_reg + h_reg) <<< 1;
            default:   v = FX_ZERO;
        endcase
        return v;
    endfunction

    always_comb begin
        opa = pick(uop.sa);
        opb = pick(uop.sb);
    end

    assign req.start = (state_reg == ST_RUN) && !issued_reg;
    assign req.op    = uop.op;

    ncs_arith u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .opa     (opa),
        .opb     (opb),
        .done    (ar_done),
        .result  (ar_result)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tlast) begin
                    state_next = (n_eff < CW'(3) || ord_err_reg || ord_hit) ? ST_OUT : ST_P_RD0;
                end
            end
            ST_P_RD0:   state_next = ST_P_RD1;
            ST_P_RD1:   state_next = ST_P_CAP;
            ST_P_CAP:   state_next = ST_RUN;
            ST_RUN: begin
                if (ar_done) begin
                    priority if (pc_reg == PC_SLOPE_END && mode_reg == MD_PRO) begin
                        state_next = ST_P_SHIFT;
                    end else if (pc_reg == PC_SOLVE_END) begin
                        state_next = ST_S_ST;
                    end else if (pc_reg == PC_SEG_END) begin
                        state_next = ST_G_DONE;
                    end else if (pc_reg == PC_BS_END) begin
                        state_next = ST_B_ST;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_P_SHIFT: state_next = ST_S_RD;
            ST_S_RD:    state_next = ST_S_CAP;
            ST_S_CAP:   state_next = ST_RUN;
            ST_S_ST:    state_next = end_row ? ST_B_END : ST_S_RD;
            ST_B_END:   state_next = ST_B_N2;
            ST_B_N2:    state_next = (n_reg == CW'(3)) ? ST_B_Z : ST_B_RD;
            ST_B_RD:    state_next = ST_B_CAP;
            ST_B_CAP:   state_next = ST_RUN;
            ST_B_ST:    state_next = first_row ? ST_B_Z : ST_B_RD;
            ST_B_Z:     state_next = ST_G_RD0;
            ST_G_RD0:   state_next = ST_G_RD1;
            ST_G_RD1:   state_next = ST_G_CAP;
            ST_G_CAP:   state_next = ST_RUN;
            ST_G_DONE:  state_next = ST_OUT;
            ST_OUT: begin
                if (m_tready) begin
                    state_next = out_last_reg ? ST_IDLE : ST_G_RD0;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ord_err_reg <= 1'b0;
            issued_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                if (s_tlast) begin
                    cnt_reg     <= '0;
                    ord_err_reg <= 1'b0;
                end else begin
                    cnt_reg     <= n_eff;
                    ord_err_reg <= ord_err_reg || ord_hit;
                end
            end
            if (state_reg == ST_RUN) begin
                issued_reg <= ar_done ? 1'b0 : 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && room) begin
            last_x_reg <= $signed(s_tdata[31:0]);
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tlast) begin
                    n_reg        <= n_eff;
                    out_idx_reg  <= '0;
                    out_c3_reg   <= '0;
                    out_c2_reg   <= '0;
                    out_c1_reg   <= '0;
                    out_c0_reg   <= '0;
                    out_last_reg <= 1'b1;
                    out_err_reg  <= (n_eff < CW'(3)) ? ERR_FEW : ERR_ORDER;
                end
            end
            ST_P_RD1: begin
                x0_reg <= widen(x_rd_reg);
                y0_reg <= widen(y_rd_reg);
            end
            ST_P_CAP: begin
                x1_reg   <= widen(x_rd_reg);
                y1_reg   <= widen(y_rd_reg);
                pc_reg   <= PC_SLOPE_FIRST;
                mode_reg <= MD_PRO;
            end
            ST_RUN: begin
                if (ar_done) begin
                    unique case (uop.dst)
                        DST_H:   h_reg   <= ar_result;
                        DST_D:   d_reg   <= ar_result;
                        DST_S:   s_reg   <= ar_result;
                        DST_H6:  h6_reg  <= ar_result;
                        DST_U0:  u0_reg  <= ar_result;
                        DST_U1:  u1_reg  <= ar_result;
                        DST_HH:  hh_reg  <= ar_result;
                        DST_SQ0: sq0_reg <= ar_result;
                        DST_SQ1: sq1_reg <= ar_result;
                        DST_P:   p_reg   <= ar_result;
                        DST_Q:   q_reg   <= ar_result;
                        DST_T:   t_reg   <= ar_result;
                        DST_T0:  t0_reg  <= ar_result;
                        DST_E:   e_reg   <= ar_result;
                        DST_RHS: rhs_reg <= ar_result;
                        DST_DEN: den_reg <= ar_result;
                        DST_C3:  c3_reg  <= ar_result;
                        DST_C2:  c2_reg  <= ar_result;
                        DST_C1:  c1_reg  <= ar_result;
                        DST_C0:  c0_reg  <= ar_result;
                        DST_G1:  g1_reg  <= ar_result;
                        default: t_reg   <= ar_result;
                    endcase
                    // branch after the slope into the solve or segment steps
                    if (pc_reg == PC_SLOPE_END && mode_reg == MD_SOLVE) begin
                        pc_reg <= PC_SOLVE_FIRST;
                    end else if (pc_reg == PC_SLOPE_END && mode_reg == MD_SEG) begin
                        pc_reg <= PC_SEG_FIRST;
                    end else begin
                        pc_reg <= pc_reg + NCS_PC_W'(1);
                    end
                end
            end
            ST_P_SHIFT: begin
                hp_reg  <= h_reg;
                sp_reg  <= s_reg;
                x0_reg  <= x1_reg;
                y0_reg  <= y1_reg;
                ap_reg  <= '0;
                bp_reg  <= '0;
                idx_reg <= IW'(1);
            end
            ST_S_CAP: begin
                x1_reg   <= widen(x_rd_reg);
                y1_reg   <= widen(y_rd_reg);
                pc_reg   <= PC_SLOPE_FIRST;
                mode_reg <= MD_SOLVE;
            end
            ST_S_ST: begin
                ap_reg <= p_reg;
                bp_reg <= q_reg;
                hp_reg <= h_reg;
                sp_reg <= s_reg;
                x0_reg <= x1_reg;
                y0_reg <= y1_reg;
                if (!end_row) begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            ST_B_END: g1_reg <= bp_reg;
            ST_B_N2:  idx_reg <= IW'(n_reg - CW'(3));
            ST_B_CAP: begin
                ap_reg   <= a_rd_reg;
                bp_reg   <= b_rd_reg;
                pc_reg   <= PC_BS_FIRST;
                mode_reg <= MD_BS;
            end
            ST_B_ST: begin
                if (!first_row) begin
                    idx_reg <= idx_reg - IW'(1);
                end
            end
            ST_B_Z: idx_reg <= '0;
            ST_G_RD1: begin
                x0_reg <= widen(x_rd_reg);
                y0_reg <= widen(y_rd_reg);
                g0_reg <= g_rd_reg;
            end
            ST_G_CAP: begin
                x1_reg   <= widen(x_rd_reg);
                y1_reg   <= widen(y_rd_reg);
                g1_reg   <= g_rd_reg;
                pc_reg   <= PC_SLOPE_FIRST;
                mode_reg <= MD_SEG;
            end
            ST_G_DONE: begin
                out_idx_reg  <= NCS_SEG_W'(idx_reg);
                out_c3_reg   <= c3_reg;
                out_c2_reg   <= c2_reg;
                out_c1_reg   <= c1_reg;
                out_c0_reg   <= c0_reg;
                out_err_reg  <= ERR_NONE;
                out_last_reg <= end_row;
            end
            ST_OUT: begin
                if (m_tready && !out_last_reg) begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            default: begin
                pc_reg <= pc_reg;
            end
        endcase
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {2'b00, out_c0_reg, out_c1_reg, out_c2_reg, out_c3_reg, out_idx_reg};
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> hdl/ncs_checker.sv
// ----------------------------------------------------------------------------
// ncs_checker
// Port-level checks on the spline coefficient engine, bound to the top level.
// ----------------------------------------------------------------------------
module ncs_checker
    import ncs_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    s_tlast,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [NCS_M_DATA_W-1:0] m_tdata,
    input logic [NCS_M_USER_W-1:0] m_tuser,
    input logic                    m_tlast
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // no knot is taken while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input open while result pending");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ERR_NONE |-> m_tlast && m_tdata == '0)
        else $error("error word not single and zero");

    // a closing knot is followed by a stall of the input
    a_close_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after closing knot");

endmodule

bind natural_cubic_spline_coefficients ncs_checker u_ncs_checker (.*);

>>> bench/tb_natural_cubic_spline_coefficients.sv
// ----------------------------------------------------------------------------
// tb_natural_cubic_spline_coefficients
// Streams knot runs into the spline engine. A bit-accurate Q32.32 model of the
// Thomas sweep and the coefficient stage predicts every segment word. A
// directed table comes first, then random runs under varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_natural_cubic_spline_coefficients;
    import ncs_pkg::*;

    typedef logic signed [63:0] fx_t;

    typedef struct {
        logic [5:0] seg;
        fx_t        c3, c2, c1, c0;
        logic [1:0] err;
        logic       lst;
    } coef_word_t;

    typedef struct {
        logic [31:0] x, y;
        bit          lst;
        bit          typed;
        logic [1:0]  code;
    } knot_row_t;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RANDOM_ITEMS   = 350;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [NCS_S_DATA_W-1:0] s_tdata = '0;   // x_pos, y_val
    logic                    s_tlast = 1'b0; // last_point
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [NCS_M_DATA_W-1:0] m_tdata;        // segment_index, c3, c2, c1, c0, pad
    logic [NCS_M_USER_W-1:0] m_tuser;        // error_code
    logic                    m_tlast;        // last_segment

    natural_cubic_spline_coefficients u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // knot store of the model and pending coefficient words
    logic signed [31:0] knot_x [NCS_MAX_POINTS];
    logic signed [31:0] knot_y [NCS_MAX_POINTS];
    fx_t                fwd_a  [NCS_MAX_POINTS];
    fx_t                fwd_b  [NCS_MAX_POINTS];
    fx_t                curv   [NCS_MAX_POINTS];
    int                 knot_cnt = 0;
    bit                 knot_disorder = 0;
    coef_word_t         pending_words [$];

    int send_idle  = 0;
    int recv_stall = 0;
    int fail_cnt   = 0;
    int quiet_cycles = 0;

    // ---------------- fixed-point arithmetic ----------------
    function automatic fx_t fx_pack(logic neg, logic [63:0] m);
        if (neg) begin
            return m[63] ? FX_MIN : -$signed(m);
        end
        return m[63] ? FX_MAX : $signed(m);
    endfunction

    function automatic logic [63:0] fx_abs(fx_t v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic fx_t q_add(fx_t a, fx_t b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? FX_MIN : FX_MAX;
        end
        return s[63:0];
    endfunction

    function automatic fx_t q_sub(fx_t a, fx_t b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? FX_MIN : FX_MAX;
        end
        return s[63:0];
    endfunction

    function automatic fx_t q_mul(fx_t a, fx_t b);
        logic [127:0] p;
        logic         neg;
        neg = a[63] ^ b[63];
        p = {64'd0, fx_abs(a)} * {64'd0, fx_abs(b)};
        p = p + 128'h8000_0000;
        if (p[127:96] != 0) begin
            return neg ? FX_MIN : FX_MAX;
        end
        return fx_pack(neg, p[95:32]);
    endfunction

    function automatic fx_t q_div(fx_t a, fx_t b);
        logic [127:0] num, q, r;
        logic [63:0]  ua, d;
        logic         neg;
        neg = a[63] ^ b[63];
        if (b == 0) begin
            if (a == 0) return 0;
            return a[63] ? FX_MIN : FX_MAX;
        end
        ua = fx_abs(a);
        d  = fx_abs(b);
        if (ua[63:32] >= d) begin
            return neg ? FX_MIN : FX_MAX;
        end
        num = {32'd0, ua, 32'd0};
        q = num / d;
        r = num % d;
        if (r >= 128'(d) - r) begin
            if (q[63:0] == '1) return neg ? FX_MIN : FX_MAX;
            q = q + 1;
        end
        return fx_pack(neg, q[63:0]);
    endfunction

    function automatic fx_t to_q32(logic signed [31:0] v);
        return fx_t'(v) <<< 16;
    endfunction

    function automatic fx_t gap_at(int i);
        return to_q32(knot_x[i + 1]) - to_q32(knot_x[i]);
    endfunction

    function automatic fx_t rise_at(int i);
        return q_div(to_q32(knot_y[i + 1]) - to_q32(knot_y[i]), gap_at(i));
    endfunction

    // tridiagonal sweep, back substitution and per-segment coefficients
    task automatic predict_segments(int n);
        fx_t        hp, hc, rhs, sub, sup, den;
        fx_t        x0, x1, y0, h, s, h6, u0, u1, hh, sq0, sq1;
        coef_word_t w;
        fwd_a[0] = 0;
        fwd_b[0] = 0;
        for (int i = 1; i + 1 < n; i++) begin
            hp  = gap_at(i - 1);
            hc  = gap_at(i);
            rhs = q_mul(q_sub(rise_at(i), rise_at(i - 1)), FX_SIX);
            sub = (i == 1) ? FX_ZERO : hp;
            sup = (i + 2 == n) ? FX_ZERO : hc;
            den = q_add(2 * (hp + hc), q_mul(sub, fwd_a[i - 1]));
            fwd_a[i] = q_div(q_sub(0, sup), den);
            fwd_b[i] = q_div(q_sub(rhs, q_mul(sub, fwd_b[i - 1])), den);
        end
        curv[n - 1] = 0;
        curv[n - 2] = fwd_b[n - 2];
        for (int j = n - 3; j >= 1; j--) begin
            curv[j] = q_add(q_mul(fwd_a[j], curv[j + 1]), fwd_b[j]);
        end
        curv[0] = 0;
        for (int i = 0; i + 1 < n; i++) begin
            x0  = to_q32(knot_x[i]);
            x1  = to_q32(knot_x[i + 1]);
            y0  = to_q32(knot_y[i]);
            h   = x1 - x0;
            s   = rise_at(i);
            h6  = q_mul(h, FX_SIX);
            u0  = q_div(curv[i], h6);
            u1  = q_div(curv[i + 1], h6);
            hh  = q_mul(h, h);
            sq0 = q_mul(x0, x0);
            sq1 = q_mul(x1, x1);
            w.seg = i[5:0];
            w.c3  = q_sub(u1, u0);
            w.c2  = q_mul(FX_THREE, q_sub(q_mul(u0, x1), q_mul(u1, x0)));
            w.c1  = q_add(s, q_sub(q_mul(u0, q_sub(hh, q_mul(FX_THREE, sq1))),
                                   q_mul(u1, q_sub(hh, q_mul(FX_THREE, sq0)))));
            w.c0  = q_add(q_sub(y0, q_mul(x0, s)),
                          q_add(q_mul(u0, q_mul(x1, q_sub(sq1, hh))),
                                q_mul(u1, q_mul(x0, q_sub(hh, sq0)))));
            w.err = ERR_NONE;
            w.lst = (i + 2 == n);
            pending_words.push_back(w);
        end
    endtask

    // model update for one accepted knot; a typed row overrides the prediction
    task automatic take_knot(knot_row_t k);
        coef_word_t w;
        int         n;
        if (knot_cnt < NCS_MAX_POINTS) begin
            if (knot_cnt > 0 && $signed(k.x) <= knot_x[knot_cnt - 1]) knot_disorder = 1;
            knot_x[knot_cnt] = k.x;
            knot_y[knot_cnt] = k.y;
            knot_cnt++;
        end
        if (!k.lst) return;
        n = knot_cnt;
        w = '{seg: 0, c3: 0, c2: 0, c1: 0, c0: 0, err: ERR_NONE, lst: 1'b1};
        if (k.typed) begin
            w.err = k.code;
            pending_words.push_back(w);
        end else if (n < 3) begin
            w.err = ERR_FEW;
            pending_words.push_back(w);
        end else if (knot_disorder) begin
            w.err = ERR_ORDER;
            pending_words.push_back(w);
        end else begin
            predict_segments(n);
        end
        knot_cnt = 0;
        knot_disorder = 0;
    endtask

    task automatic send_knot(knot_row_t k);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {k.y, k.x};
        s_tlast  = k.lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        take_knot(k);
    endtask

    // one random run: mostly ordered knots, some broken order, some noise
    task automatic send_run(ref int sent, ref int long_runs);
        int          kind, n;
        int          xs[$];
        logic [31:0] base;
        knot_row_t   k;
        kind = $urandom_range(0, 19);
        n = $urandom_range(3, 8);
        if (kind == 14 && long_runs < 2) begin
            n = ($urandom_range(0, 1) != 0) ? 66 : 64;   // extra knots get dropped
            long_runs++;
        end
        if (kind >= 17) n = $urandom_range(1, 4);
        xs = {};
        if ($urandom_range(0, 1) != 0) begin
            for (int i = 0; i < n; i++) xs.push_back(int'($urandom));
            xs.sort();
        end else begin
            base = $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
            for (int i = 0; i < n; i++) begin
                xs.push_back(int'(base));
                base = base + $urandom_range(1, 32'h0010_0000);
            end
        end
        if (kind == 15 || kind == 16) begin
            xs[$urandom_range(1, n - 1)] = xs[0];
        end else if (kind >= 17) begin
            foreach (xs[i]) xs[i] = int'($urandom);
        end
        for (int i = 0; i < n; i++) begin
            k = '{x: xs[i], y: $urandom, lst: (i == n - 1), typed: 0, code: ERR_NONE};
            send_knot(k);
            sent++;
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // compare each accepted word with the oldest prediction
    always @(posedge aclk) begin
        coef_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: seg %0d", m_tdata[5:0]);
                fail_cnt++;
            end else begin
                w = pending_words.pop_front();
                if (m_tdata[5:0] !== w.seg) begin
                    $error("segment_index exp %0d got %0d", w.seg, m_tdata[5:0]);
                    fail_cnt++;
                end
                if (m_tdata[69:6] !== w.c3) begin
                    $error("coef_cubic exp %h got %h", w.c3, m_tdata[69:6]);
                    fail_cnt++;
                end
                if (m_tdata[133:70] !== w.c2) begin
                    $error("coef_square exp %h got %h", w.c2, m_tdata[133:70]);
                    fail_cnt++;
                end
                if (m_tdata[197:134] !== w.c1) begin
                    $error("coef_linear exp %h got %h", w.c1, m_tdata[197:134]);
                    fail_cnt++;
                end
                if (m_tdata[261:198] !== w.c0) begin
                    $error("coef_const exp %h got %h", w.c0, m_tdata[261:198]);
                    fail_cnt++;
                end
                if (m_tuser !== w.err) begin
                    $error("error_code exp %0d got %0d", w.err, m_tuser);
                    fail_cnt++;
                end
                if (m_tlast !== w.lst) begin
                    $error("last_segment exp %0d got %0d", w.lst, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: cycles in which no word moves on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("natural_cubic_spline_coefficients: mismatch");
            $finish;
        end
    end

    initial begin
        knot_row_t dir_tab [];
        int        sent;
        int        long_runs;
        sent = 0;
        long_runs = 0;
        dir_tab = '{
            // single knot, then two knots: too few
            '{32'h0000_0000, 32'h0000_0000, 1, 1, ERR_FEW},
            '{32'h0000_0000, 32'h0000_0000, 0, 0, ERR_NONE},
            '{32'h0001_0000, 32'h0000_0005, 1, 1, ERR_FEW},
            // x goes back down
            '{32'h0000_000A, 32'h0000_0001, 0, 0, ERR_NONE},
            '{32'h0000_0005, 32'h0000_0002, 0, 0, ERR_NONE},
            '{32'h0000_0014, 32'h0000_0003, 1, 1, ERR_ORDER},
            // repeated x
            '{32'h0000_0007, 32'h0000_0001, 0, 0, ERR_NONE},
            '{32'h0000_0007, 32'h0000_0002, 0, 0, ERR_NONE},
            '{32'h0000_0009, 32'h0000_0003, 1, 1, ERR_ORDER},
            // extreme abscissas and ordinates, saturating coefficients
            '{32'h8000_0000, 32'h7FFF_FFFF, 0, 0, ERR_NONE},
            '{32'hFFFF_FFFF, 32'h8000_0000, 0, 0, ERR_NONE},
            '{32'h0000_0000, 32'hFFFF_FFFF, 0, 0, ERR_NONE},
            '{32'h7FFF_FFFF, 32'h0000_0000, 1, 0, ERR_NONE},
            // plain zigzag
            '{32'h0000_0000, 32'h0000_0000, 0, 0, ERR_NONE},
            '{32'h0001_0000, 32'h0001_0000, 0, 0, ERR_NONE},
            '{32'h0002_0000, 32'h0000_0000, 0, 0, ERR_NONE},
            '{32'h0003_0000, 32'h0001_0000, 1, 0, ERR_NONE},
            // minimal valid run, tiny spacing
            '{32'h0000_0001, 32'h5555_5555, 0, 0, ERR_NONE},
            '{32'h0000_0002, 32'hAAAA_AAAA, 0, 0, ERR_NONE},
            '{32'h0000_0003, 32'h0000_0001, 1, 0, ERR_NONE}
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle  = 6;
        recv_stall = 66;
        foreach (dir_tab[i]) send_knot(dir_tab[i]);

        while (sent < RANDOM_ITEMS) begin
            if (sent < RANDOM_ITEMS / 3) begin
                send_idle  = 6;
                recv_stall = 66;
            end else if (sent < 2 * RANDOM_ITEMS / 3) begin
                send_idle  = 66;
                recv_stall = 6;
            end else begin
                send_idle  = 0;
                recv_stall = 0;
            end
            send_run(sent, long_runs);
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (pending_words.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("natural_cubic_spline_coefficients: match");
        end else begin
            $display("natural_cubic_spline_coefficients: mismatch");
        end
        $finish;
    end

endmodule
